>>> rtl/pcx_pkg.sv
// Shared types and constants for the RLE palette expander.
// No dependencies; imported by the placer and the top level.
package pcx_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W = 13;  // config register width
  localparam int COL_W = 12;  // column / row output width
  localparam int ROW_W = 13;  // row counter, can reach the height itself

  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_LEN_MASK = 8'h3F;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] GLASS_LIMIT = 8'd16;
  localparam logic [7:0] GLASS_ALPHA_BASE = 8'd50;
  localparam logic [7:0] GLASS_ALPHA_STEP = 8'd6;
  localparam logic [7:0] GLASS_RED = 8'd200;
  localparam logic [7:0] GLASS_GREEN = 8'd220;
  localparam logic [7:0] GLASS_BLUE = 8'd245;

  typedef enum logic [1:0] {
    CMD_PAL_WRITE = 2'd0,
    CMD_START     = 2'd1,
    CMD_DATA      = 2'd2
  } cmd_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_GLASS  = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;   // clamped to MAX_DIMENSION
    logic [DIM_W-1:0] stride;  // clamped to 1..MAX_DIMENSION
    logic [DIM_W-1:0] height;  // clamped to 1..MAX_DIMENSION
  } dims_t;

  typedef struct packed {
    pos_t             pos_nxt;
    logic             full_nxt;
    logic             emit;
    logic [COL_W-1:0] pix_col;
    logic [COL_W-1:0] pix_row;
    logic             done;
  } plc_res_t;

endpackage

>>> rtl/pcx_palette_ram.sv
// Palette memory: one write port, one registered read port.
// No dependencies.
module pcx_palette_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/pcx_placer.sv
// Position logic for one decoded index: line wrap, visibility, end of image.
// Depends on pcx_pkg.
module pcx_placer
  import pcx_pkg::*;
(
  input  pos_t     pos,
  input  dims_t    dims,
  output plc_res_t res
);

  logic             wrap0;
  logic [COL_W-1:0] col0;
  logic [ROW_W-1:0] row0;
  logic [ROW_W-1:0] row0_inc;
  logic             dead;
  logic [DIM_W-1:0] col1;
  logic             wrap1;
  logic [DIM_W-1:0] vis_cols;
  logic [DIM_W-1:0] last_col;

  always_comb begin
    // a stride shrunk mid-image can leave the column past the line end
    wrap0    = {1'b0, pos.col} >= dims.stride;
    col0     = wrap0 ? '0 : pos.col;
    row0     = wrap0 ? pos.row + ROW_W'(1) : pos.row;
    dead     = row0 >= dims.height;
    col1     = {1'b0, col0} + DIM_W'(1);
    wrap1    = col1 >= dims.stride;
    row0_inc = row0 + ROW_W'(1);
    vis_cols = (dims.width < dims.stride) ? dims.width : dims.stride;
    last_col = vis_cols - DIM_W'(1);

    res.emit    = !dead && ({1'b0, col0} < dims.width);
    res.pix_col = col0;
    res.pix_row = row0[COL_W-1:0];
    res.done    = (row0 == dims.height - ROW_W'(1)) && ({1'b0, col0} == last_col);

    if (dead) begin
      res.pos_nxt.col = col0;
      res.pos_nxt.row = row0;
      res.full_nxt    = 1'b1;
    end else if (wrap1) begin
      res.pos_nxt.col = '0;
      res.pos_nxt.row = row0_inc;
      res.full_nxt    = row0_inc >= dims.height;
    end else begin
      res.pos_nxt.col = col1[COL_W-1:0];
      res.pos_nxt.row = row0;
      res.full_nxt    = 1'b0;
    end
  end

endmodule

>>> rtl/pcx_rle_palette_expander_unit.sv
// RLE palette expander: decodes run-length index bytes into positioned RGBA pixels.
// The value byte of a run of n starts n placement steps, one per line position,
// padding columns included, fewer when the image fills first. A pixel passes from
// stage A, where its palette read is in flight, to the output register; inside a
// run it waits in stage A until the next visible pixel is placed or the run ends,
// since only then is its last flag known. A stalled output holds placement. Input
// is not taken while a run expands, so palette writes never meet a pending read.
// The palette is not cleared after reset; entries must be written before use.
// Depends on pcx_pkg, pcx_placer and pcx_palette_ram.
module pcx_rle_palette_expander_unit
  import pcx_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [7:0]       in_data_byte,
  input  logic [7:0]       in_pal_index,
  input  logic [7:0]       in_pal_red,
  input  logic [7:0]       in_pal_green,
  input  logic [7:0]       in_pal_blue,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [COL_W-1:0] out_pixel_column,
  output logic [COL_W-1:0] out_pixel_row,
  output logic             out_last_of_run,
  output logic             out_image_done
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lo);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

  // configuration, stored already clamped
  dims_t dims_r;
  logic  glass_r;

  // decoder state
  pos_t       pos_r;
  logic       full_r;
  logic       pend_r;
  logic [5:0] run_len_r;
  logic       run_act_r;
  logic [5:0] run_cnt_r;
  logic [7:0] run_byte_r;

  // stage A: palette read in flight, last flag may still be open
  logic             a_valid_r;
  logic             a_final_r;
  logic [7:0]       a_idx_r;
  logic [COL_W-1:0] a_col_r;
  logic [COL_W-1:0] a_row_r;
  logic             a_done_r;

  // stage B: output register
  logic b_valid_r;

  logic        b_free;
  logic        step_ok;
  logic        in_acc;
  logic        is_data;
  logic        is_marker;
  logic        lit_place;
  logic        run_place;
  logic        place;
  logic        new_emit;
  logic        run_end;
  logic        a_release;
  logic [7:0]  place_idx;
  logic [23:0] pal_rdata;
  plc_res_t    plc;

  logic        glass_hit;
  logic [7:0]  glass_alpha;

  assign b_free    = !b_valid_r || out_ready;
  assign step_ok   = !a_valid_r || b_free;
  assign in_ready  = !run_act_r && step_ok;
  assign in_acc    = in_valid && in_ready;
  assign is_data   = in_acc && (in_cmd == CMD_DATA) && !full_r;
  assign is_marker = (in_data_byte & RUN_MARK) == RUN_MARK;
  assign lit_place = is_data && !pend_r && !is_marker;
  assign run_place = run_act_r && step_ok;
  assign place     = lit_place || run_place;
  assign place_idx = run_act_r ? run_byte_r : in_data_byte;
  assign new_emit  = place && plc.emit;
  assign run_end   = run_place && ((run_cnt_r == 6'd1) || plc.full_nxt);
  // an open pixel leaves only once the next visible one shows it was not last
  assign a_release = a_valid_r && b_free && (a_final_r || new_emit);

  pcx_placer u_placer (
    .pos  (pos_r),
    .dims (dims_r),
    .res  (plc)
  );

  pcx_palette_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .WIDTH (24)
  ) u_pal (
    .clk   (clk),
    .we    (in_acc && (in_cmd == CMD_PAL_WRITE)),
    .waddr (in_pal_index[PAL_AW-1:0]),
    .wdata ({in_pal_red, in_pal_green, in_pal_blue}),
    .re    (new_emit),
    .raddr (place_idx[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.width  <= DIM_W'(1);
      dims_r.stride <= DIM_W'(1);
      dims_r.height <= DIM_W'(1);
      glass_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  dims_r.width  <= clamp_dim(cfg_wdata, '0);
        REG_STRIDE: dims_r.stride <= clamp_dim(cfg_wdata, DIM_W'(1));
        REG_HEIGHT: dims_r.height <= clamp_dim(cfg_wdata, DIM_W'(1));
        REG_GLASS:  glass_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      full_r    <= 1'b1;
      pend_r    <= 1'b0;
      run_len_r <= '0;
      run_act_r <= 1'b0;
      run_cnt_r <= '0;
    end else begin
      if (in_acc && (in_cmd == CMD_START)) begin
        pos_r     <= '0;
        full_r    <= 1'b0;
        pend_r    <= 1'b0;
        run_len_r <= '0;
      end
      if (is_data) begin
        if (pend_r) begin
          pend_r <= 1'b0;
          if (run_len_r != '0) begin
            run_act_r <= 1'b1;
            run_cnt_r <= run_len_r;
          end
        end else if (is_marker) begin
          pend_r    <= 1'b1;
          run_len_r <= 6'(in_data_byte & RUN_LEN_MASK);
        end
      end
      if (place) begin
        pos_r  <= plc.pos_nxt;
        full_r <= plc.full_nxt;
      end
      if (run_place) begin
        run_cnt_r <= run_cnt_r - 6'd1;
        if (run_end) begin
          run_act_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_data && pend_r) begin
      run_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_final_r <= 1'b0;
    end else if (new_emit) begin
      a_valid_r <= 1'b1;
      a_final_r <= lit_place || run_end;
    end else if (a_release) begin
      a_valid_r <= 1'b0;
    end else if (run_end && a_valid_r) begin
      a_final_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (new_emit) begin
      a_idx_r  <= place_idx;
      a_col_r  <= plc.pix_col;
      a_row_r  <= plc.pix_row;
      a_done_r <= plc.done;
    end
  end

  always_comb begin
    glass_hit   = glass_r && (a_idx_r != 8'd0) && (a_idx_r < GLASS_LIMIT);
    glass_alpha = GLASS_ALPHA_BASE + {4'd0, a_idx_r[3:0]} * GLASS_ALPHA_STEP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_release) begin
      b_valid_r <= 1'b1;
    end else if (out_ready) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_release) begin
      if (glass_hit) begin
        out_red   <= GLASS_RED;
        out_green <= GLASS_GREEN;
        out_blue  <= GLASS_BLUE;
        out_alpha <= glass_alpha;
      end else begin
        out_red   <= pal_rdata[23:16];
        out_green <= pal_rdata[15:8];
        out_blue  <= pal_rdata[7:0];
        out_alpha <= (a_idx_r == 8'd0) ? 8'd0 : ALPHA_OPAQUE;
      end
      out_pixel_column <= a_col_r;
      out_pixel_row    <= a_row_r;
      out_last_of_run  <= a_final_r;
      out_image_done   <= a_done_r;
    end
  end

  assign out_valid = b_valid_r;

  // an open last flag exists only while its run is still expanding
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_final_r) |-> run_act_r)
    else $error("open pixel held without an active run");

  assert property (@(posedge clk) disable iff (!rst_n)
    run_act_r |-> (run_cnt_r != 6'd0))
    else $error("run active with zero count");

  // the closing pixel of an image is always the last one of its beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_done) |-> out_last_of_run)
    else $error("image done without last of run");

endmodule

>>> verif/pcx_rle_palette_expander_unit_test.sv
// Self-checking testbench for pcx_rle_palette_expander_unit: a directed table, then random phases.
// Every pixel is checked, against a behavioral decoder kept in this file or against a pixel given in the table.
// Depends on rtl/pcx_pkg.sv and rtl/pcx_rle_palette_expander_unit.sv.
module pcx_rle_palette_expander_unit_test
  import pcx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;   // a run of 63 plus pipeline, with margin
  localparam int RANDOM_ITEMS = 160;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    logic [7:0] pidx;
    logic [7:0] pr;
    logic [7:0] pg;
    logic [7:0] pb;
  } beat_t;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
    logic        done;
  } pixel_t;

  typedef enum {ROW_BEAT, ROW_PIXEL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    beat_t       b;
    pixel_t      px;
    logic [1:0]  reg_idx;
    logic [12:0] reg_val;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_cmd = '0;
  logic [7:0]       in_data_byte = '0;
  logic [7:0]       in_pal_index = '0;
  logic [7:0]       in_pal_red = '0;
  logic [7:0]       in_pal_green = '0;
  logic [7:0]       in_pal_blue = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [7:0]       out_alpha;
  logic [COL_W-1:0] out_pixel_column;
  logic [COL_W-1:0] out_pixel_row;
  logic             out_last_of_run;
  logic             out_image_done;

  pcx_rle_palette_expander_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_data_byte     (in_data_byte),
    .in_pal_index     (in_pal_index),
    .in_pal_red       (in_pal_red),
    .in_pal_green     (in_pal_green),
    .in_pal_blue      (in_pal_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_last_of_run  (out_last_of_run),
    .out_image_done   (out_image_done)
  );

  always #10 clk = ~clk;

  // decoder state mirrored by the testbench
  logic [23:0] pal_mem [PAL_ENTRIES];
  bit          pal_written [PAL_ENTRIES];
  logic        run_armed;
  logic [5:0]  run_len;
  int          col_pos;
  int          row_pos;
  logic        img_full;
  logic [12:0] reg_width;
  logic [12:0] reg_stride;
  logic [12:0] reg_height;
  logic        reg_glass;

  pixel_t    step_px [$];
  pixel_t    pixels_due [$];
  stim_row_t stim_rows [$];
  pixel_t    blank_px;
  pixel_t    seen_px;
  int        errors = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        beats_sent = 0;
  logic [8:0] rx_phase = '0;

  function automatic int dim_limit(input logic [12:0] v, input int lo);
    int x;
    x = int'(v);
    if (x < lo) return lo;
    if (x > MAX_DIMENSION) return MAX_DIMENSION;
    return x;
  endfunction

  task automatic place_pixel(input logic [7:0] idx);
    int w, s, h, last_col;
    logic [23:0] rgb;
    pixel_t px;
    w = dim_limit(reg_width, 0);
    s = dim_limit(reg_stride, 1);
    h = dim_limit(reg_height, 1);
    if (col_pos >= s) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) begin
      img_full = 1'b1;
      return;
    end
    if (col_pos < w) begin
      rgb = pal_mem[idx];
      px.red = rgb[23:16];
      px.green = rgb[15:8];
      px.blue = rgb[7:0];
      px.alpha = (idx == 8'd0) ? 8'd0 : ALPHA_OPAQUE;
      last_col = ((w < s) ? w : s) - 1;
      if (reg_glass && idx >= 8'd1 && idx < GLASS_LIMIT) begin
        px.red = GLASS_RED;
        px.green = GLASS_GREEN;
        px.blue = GLASS_BLUE;
        px.alpha = GLASS_ALPHA_BASE + idx * GLASS_ALPHA_STEP;
      end
      px.col = col_pos[11:0];
      px.row = row_pos[11:0];
      px.last = 1'b0;
      px.done = (row_pos == h - 1) && (col_pos == last_col);
      step_px.push_back(px);
    end
    col_pos++;
    if (col_pos >= s) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) img_full = 1'b1;
    end
  endtask

  // pixels caused by one accepted beat land in step_px
  task automatic decode_beat(input beat_t b);
    int n;
    pixel_t px;
    step_px.delete();
    case (b.cmd)
      CMD_PAL_WRITE: begin
        pal_mem[b.pidx] = {b.pr, b.pg, b.pb};
        pal_written[b.pidx] = 1'b1;
      end
      CMD_START: begin
        col_pos = 0;
        row_pos = 0;
        run_armed = 1'b0;
        run_len = '0;
        img_full = 1'b0;
      end
      CMD_DATA: begin
        if (!img_full) begin
          if (run_armed) begin
            run_armed = 1'b0;
            n = int'(run_len);
            for (int i = 0; i < n && !img_full; i++) place_pixel(b.data);
          end else if ((b.data & RUN_MARK) == RUN_MARK) begin
            run_armed = 1'b1;
            run_len = b.data[5:0];
          end else begin
            place_pixel(b.data);
          end
        end
      end
      default: ;
    endcase
    if (step_px.size() > 0) begin
      px = step_px.pop_back();
      px.last = 1'b1;
      step_px.push_back(px);
    end
  endtask

  function automatic logic [7:0] pick_index(input bit literal);
    logic [7:0] c;
    for (int i = 0; i < 64; i++) begin
      c = literal ? 8'($urandom_range(8'hBF, 0)) : 8'($urandom_range(8'hFF, 0));
      if (pal_written[c]) return c;
    end
    return 8'd1;
  endfunction

  // keep every palette read on a written entry
  function automatic logic [7:0] safe_data(input logic [7:0] d);
    if (img_full) return d;
    if (run_armed) return pal_written[d] ? d : pick_index(1'b0);
    if ((d & RUN_MARK) == RUN_MARK) return d;
    return pal_written[d] ? d : pick_index(1'b1);
  endfunction

  function automatic beat_t random_beat(input logic [1:0] cmd);
    beat_t b;
    b.cmd = cmd;
    b.data = 8'($urandom);
    b.pidx = 8'($urandom);
    b.pr = 8'($urandom);
    b.pg = 8'($urandom);
    b.pb = 8'($urandom);
    return b;
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input pixel_t want);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= b.cmd;
    in_data_byte <= b.data;
    in_pal_index <= b.pidx;
    in_pal_red <= b.pr;
    in_pal_green <= b.pg;
    in_pal_blue <= b.pb;
    do @(posedge clk); while (!in_ready);
    decode_beat(b);
    if (typed) pixels_due.push_back(want);
    else foreach (step_px[i]) pixels_due.push_back(step_px[i]);
  endtask

  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  reg_width = val;
      REG_STRIDE: reg_stride = val;
      REG_HEIGHT: reg_height = val;
      REG_GLASS:  reg_glass = val[0];
      default: ;
    endcase
  endtask

  task automatic row_beat(input logic [1:0] cmd, input logic [7:0] data, input logic [7:0] pidx,
                          input logic [7:0] pr, input logic [7:0] pg, input logic [7:0] pb);
    stim_row_t r;
    r.kind = ROW_BEAT;
    r.b = '{cmd, data, pidx, pr, pg, pb};
    stim_rows.push_back(r);
  endtask

  task automatic row_pixel(input logic [7:0] data, input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue, input logic [7:0] alpha,
                           input logic [11:0] col, input logic [11:0] row, input logic done);
    stim_row_t r;
    r.kind = ROW_PIXEL;
    r.b = '{CMD_DATA, data, 8'h00, 8'h00, 8'h00, 8'h00};
    r.px = '{red, green, blue, alpha, col, row, 1'b1, done};
    stim_rows.push_back(r);
  endtask

  task automatic row_cfg(input logic [1:0] idx, input logic [12:0] val);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    stim_rows.push_back(r);
  endtask

  function automatic logic [12:0] pick_dim(input int typical_max);
    case ($urandom_range(9, 0))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'(MAX_DIMENSION);
      3: return 13'h1FFF;
      default: return 13'($urandom_range(typical_max, 1));
    endcase
  endfunction

  task automatic random_phase();
    logic [12:0] stride_v, width_v;
    int n, pick;
    beat_t b;
    settle(DRAIN_CYCLES);
    stride_v = pick_dim(10);
    width_v = ($urandom_range(5, 0) == 0) ? stride_v + 13'($urandom_range(3, 1)) : pick_dim(10);
    write_reg(REG_WIDTH, width_v);
    write_reg(REG_STRIDE, stride_v);
    write_reg(REG_HEIGHT, pick_dim(3));
    write_reg(REG_GLASS, 13'($urandom_range(1, 0)));
    burst_left = ($urandom_range(3, 0) == 0) ? 32'h4000_0000 : 0;
    // some phases carry on mid-image with the new registers
    if ($urandom_range(2, 0) != 0) begin
      send_beat(random_beat(CMD_START), 1'b0, blank_px);
      beats_sent++;
    end
    n = $urandom_range(20, 8);
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        send_beat(random_beat(CMD_PAL_WRITE), 1'b0, blank_px);
        beats_sent++;
      end else if (pick < 12) begin
        send_beat(random_beat(CMD_UNDEF), 1'b0, blank_px);
        beats_sent++;
      end else if (pick < 16) begin
        b = random_beat(CMD_DATA);
        b.data = safe_data(b.data);
        send_beat(b, 1'b0, blank_px);
        beats_sent++;
      end else if (pick < 20) begin
        send_beat(random_beat(CMD_START), 1'b0, blank_px);
        beats_sent++;
      end else if (pick < 55) begin
        b = random_beat(CMD_DATA);
        b.data = safe_data(8'($urandom_range(8'hBF, 0)));
        send_beat(b, 1'b0, blank_px);
        beats_sent++;
      end else begin
        b = random_beat(CMD_DATA);
        b.data = safe_data(RUN_MARK | 8'($urandom_range(63, 0)));
        send_beat(b, 1'b0, blank_px);
        b = random_beat(CMD_DATA);
        b.data = safe_data(b.data);
        send_beat(b, 1'b0, blank_px);
        beats_sent += 2;
      end
      if ($urandom_range(39, 0) == 0) settle(0);
    end
  endtask

  // receiver: free-flowing, random, periodic long stalls, coin flip
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(3, 0) != 0);
      2'd2: out_ready <= (rx_phase[3:0] < 4'd5);
      default: out_ready <= ($urandom_range(1, 0) == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel beat with nothing expected: col %0d row %0d",
               out_pixel_column, out_pixel_row);
        errors++;
      end else begin
        seen_px = pixels_due.pop_front();
        check_field("red", 32'(seen_px.red), 32'(out_red));
        check_field("green", 32'(seen_px.green), 32'(out_green));
        check_field("blue", 32'(seen_px.blue), 32'(out_blue));
        check_field("alpha", 32'(seen_px.alpha), 32'(out_alpha));
        check_field("pixel_column", 32'(seen_px.col), 32'(out_pixel_column));
        check_field("pixel_row", 32'(seen_px.row), 32'(out_pixel_row));
        check_field("last_of_run", 32'(seen_px.last), 32'(out_last_of_run));
        check_field("image_done", 32'(seen_px.done), 32'(out_image_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("pcx_rle_palette_expander_unit verification failed");
      $finish;
    end
  end

  initial begin
    foreach (pal_mem[i]) begin
      pal_mem[i] = '0;
      pal_written[i] = 1'b0;
    end
    run_armed = 1'b0;
    run_len = '0;
    col_pos = 0;
    row_pos = 0;
    img_full = 1'b1;
    reg_width = 13'd1;
    reg_stride = 13'd1;
    reg_height = 13'd1;
    reg_glass = 1'b0;
    blank_px = '{8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0};

    // no image started yet: data is dropped
    row_beat(CMD_DATA, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);
    row_cfg(REG_WIDTH, 13'd4);
    row_cfg(REG_STRIDE, 13'd6);
    row_cfg(REG_HEIGHT, 13'd2);
    row_cfg(REG_GLASS, 13'd0);
    row_beat(CMD_PAL_WRITE, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56);
    row_beat(CMD_PAL_WRITE, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    row_beat(CMD_PAL_WRITE, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00);
    row_beat(CMD_PAL_WRITE, 8'h00, 8'h0F, 8'h80, 8'h40, 8'h20);
    row_beat(CMD_PAL_WRITE, 8'h00, 8'hBF, 8'hA5, 8'h5A, 8'hC3);
    // undefined command must not touch entry 255
    row_beat(CMD_UNDEF, 8'h07, 8'hFF, 8'h00, 8'h00, 8'h00);
    row_beat(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    row_pixel(8'h00, 8'h12, 8'h34, 8'h56, 8'd0, 12'd0, 12'd0, 1'b0);
    // longest run, cut short at the end of the image
    row_beat(CMD_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    row_beat(CMD_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    row_beat(CMD_DATA, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);
    // width above stride, glass tint
    row_cfg(REG_WIDTH, 13'd8);
    row_cfg(REG_HEIGHT, 13'd1);
    row_cfg(REG_GLASS, 13'd1);
    row_beat(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    row_pixel(8'h01, GLASS_RED, GLASS_GREEN, GLASS_BLUE, 8'd56, 12'd0, 12'd0, 1'b0);
    row_pixel(8'h0F, GLASS_RED, GLASS_GREEN, GLASS_BLUE, 8'd140, 12'd1, 12'd0, 1'b0);
    row_beat(CMD_DATA, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00);
    row_beat(CMD_DATA, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00);
    // palette write between a marker and its value keeps the run pending
    row_beat(CMD_DATA, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00);
    row_beat(CMD_PAL_WRITE, 8'h00, 8'h10, 8'h11, 8'h22, 8'h33);
    row_beat(CMD_DATA, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00);
    row_pixel(8'hBF, 8'hA5, 8'h5A, 8'hC3, 8'd255, 12'd5, 12'd0, 1'b1);
    // zero registers: width 0 shows nothing, stride and height act as 1
    row_cfg(REG_WIDTH, 13'd0);
    row_cfg(REG_STRIDE, 13'd0);
    row_cfg(REG_HEIGHT, 13'd0);
    row_cfg(REG_GLASS, 13'd0);
    row_beat(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    row_beat(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_CFG: begin
          settle(DRAIN_CYCLES);
          write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
        end
        ROW_PIXEL: send_beat(stim_rows[i].b, 1'b1, stim_rows[i].px);
        default:   send_beat(stim_rows[i].b, 1'b0, blank_px);
      endcase
    end

    while (beats_sent < RANDOM_ITEMS) random_phase();

    settle(DRAIN_CYCLES);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("pcx_rle_palette_expander_unit verification clean");
    end else begin
      $display("pcx_rle_palette_expander_unit verification failed");
    end
    $finish;
  end

endmodule
